### rtl/udpcs_pkg.sv
// ----------------------------------------------------------------------------
// udpcs_pkg
// Shared types, constants and helpers for the UDP checksum engine.
// ----------------------------------------------------------------------------
package udpcs_pkg;

  // Protocol number of UDP as it enters the pseudo-header
  localparam logic [15:0] UdpProto = 16'd17;

  // Byte counter saturates here; anything above 65535 is flagged
  localparam logic [16:0] LenCap = 17'h10000;

  // Largest length that the result can report
  localparam logic [15:0] LenMax = 16'hFFFF;

  // Default number of finished datagrams held between front and back
  localparam int unsigned QueueDepthDef = 2;

  // Per-datagram record handed from the front end to the back end
  typedef struct packed {
    logic [15:0] run_sum;
    logic [15:0] len;
    logic        over;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
  } rec_t;

  // One's-complement add of two 16-bit words with end-around carry
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

### rtl/udpcs_if.sv
// ----------------------------------------------------------------------------
// udpcs_in_if / udpcs_out_if
// Valid/ready channels carrying datagram words in and checksum results out.
// ----------------------------------------------------------------------------
interface udpcs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] data_word;
  logic        odd_tail;
  logic        last_word;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;

  modport source (
    output valid, data_word, odd_tail, last_word, src_ip, dst_ip,
    input  ready
  );
  modport sink (
    input  valid, data_word, odd_tail, last_word, src_ip, dst_ip,
    output ready
  );
endinterface

interface udpcs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] checksum;
  logic [15:0] udp_length;
  logic        too_long;

  modport source (
    output valid, checksum, udp_length, too_long,
    input  ready
  );
  modport sink (
    input  valid, checksum, udp_length, too_long,
    output ready
  );
endinterface

### rtl/udpcs_front.sv
// ----------------------------------------------------------------------------
// udpcs_front
// Accepts datagram words, keeps the running one's-complement sum and the
// byte count, and emits one record per datagram on its last word.
// ----------------------------------------------------------------------------
module udpcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  udpcs_in_if.sink            in_i,
  input  logic                space_i,
  output logic                push_o,
  output udpcs_pkg::rec_t     rec_o
);

  logic [15:0] sum_q, sum_d, sum_new;
  logic [16:0] cnt_q, cnt_d, cnt_new;
  logic [17:0] cnt_sum;
  logic [15:0] word_eff;
  logic [1:0]  nbytes;
  logic        tail;
  logic        accept;

  assign in_i.ready = space_i;
  assign accept     = in_i.valid && space_i;

  // Mask the pad byte of an odd tail and count one byte for it
  assign tail     = in_i.last_word && in_i.odd_tail;
  assign word_eff = tail ? {in_i.data_word[15:8], 8'h00} : in_i.data_word;
  assign nbytes   = tail ? 2'd1 : 2'd2;

  // Accumulate and saturate the byte count
  assign cnt_sum = {1'b0, cnt_q} + {16'd0, nbytes};
  assign cnt_new = (cnt_sum > {1'b0, udpcs_pkg::LenCap}) ? udpcs_pkg::LenCap
                                                         : cnt_sum[16:0];
  assign sum_new = udpcs_pkg::oc_add(sum_q, word_eff);

  // Advance on every accepted item, clear after the last one
  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (accept) begin
      if (in_i.last_word) begin
        sum_d = '0;
        cnt_d = '0;
      end else begin
        sum_d = sum_new;
        cnt_d = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else begin
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Hand the finished datagram to the queue
  assign push_o        = accept && in_i.last_word;
  assign rec_o.run_sum = sum_new;
  assign rec_o.over    = cnt_new[16];
  assign rec_o.len     = cnt_new[16] ? udpcs_pkg::LenMax : cnt_new[15:0];
  assign rec_o.src_ip  = in_i.src_ip;
  assign rec_o.dst_ip  = in_i.dst_ip;

  // State is back at zero after a last word
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (sum_q == 16'd0) && (cnt_q == 17'd0))
    else $error("front state not cleared after last item");

endmodule

### rtl/udpcs_queue.sv
// ----------------------------------------------------------------------------
// udpcs_queue
// Small flop-based FIFO of datagram records between front and back end.
// ----------------------------------------------------------------------------
module udpcs_queue #(
  parameter int unsigned Depth = udpcs_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  udpcs_pkg::rec_t     rec_i,
  output logic                space_o,
  input  logic                pop_i,
  output logic                valid_o,
  output udpcs_pkg::rec_t     rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  udpcs_pkg::rec_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign space_o = (cnt_q != CntFull);
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap and track the fill
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store records, no reset on payload
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= rec_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue fill exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with pointers apart");

endmodule

### rtl/udpcs_back.sv
// ----------------------------------------------------------------------------
// udpcs_back
// Adds the pseudo-header to a datagram sum, folds, inverts and presents
// the checksum in an output register; two stages with valid/ready flow.
// ----------------------------------------------------------------------------
module udpcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  udpcs_pkg::rec_t     rec_i,
  output logic                pop_o,
  udpcs_out_if.source         out_o
);

  // Stage A: address halves summed, rest carried along
  logic        a_vld_q;
  logic [17:0] a_ip_q;
  logic [15:0] a_sum_q, a_len_q;
  logic        a_over_q;
  logic [17:0] ip_sum;
  logic        a_ready;

  // Stage B: output register
  logic        o_vld_q;
  logic [15:0] o_chk_q, o_len_q;
  logic        o_over_q;
  logic        o_ready;

  logic [18:0] total;
  logic [16:0] fold1;
  logic [15:0] fold2, chk;

  assign o_ready = !o_vld_q || out_o.ready;
  assign a_ready = !a_vld_q || o_ready;
  assign pop_o   = valid_i && a_ready;

  assign ip_sum = {2'b00, rec_i.src_ip[31:16]} + {2'b00, rec_i.src_ip[15:0]}
                + {2'b00, rec_i.dst_ip[31:16]} + {2'b00, rec_i.dst_ip[15:0]};

  // Full sum, then fold the carries back in twice
  assign total = {1'b0, a_ip_q} + {3'b000, a_sum_q} + {3'b000, a_len_q}
               + {3'b000, udpcs_pkg::UdpProto};
  assign fold1 = {1'b0, total[15:0]} + {14'd0, total[18:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};
  assign chk   = (~fold2 == 16'd0) ? 16'hFFFF : ~fold2;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_ready) a_vld_q <= valid_i;
      if (o_ready) o_vld_q <= a_vld_q;
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_ip_q   <= ip_sum;
      a_sum_q  <= rec_i.run_sum;
      a_len_q  <= rec_i.len;
      a_over_q <= rec_i.over;
    end
    if (o_ready && a_vld_q) begin
      o_chk_q  <= chk;
      o_len_q  <= a_len_q;
      o_over_q <= a_over_q;
    end
  end

  assign out_o.valid      = o_vld_q;
  assign out_o.checksum   = o_chk_q;
  assign out_o.udp_length = o_len_q;
  assign out_o.too_long   = o_over_q;

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && !o_ready) |=> a_vld_q && $stable(a_sum_q) && $stable(a_ip_q))
    else $error("stage A lost or changed a stalled record");

endmodule

### rtl/udp_checksum_pseudo_header.sv
// ----------------------------------------------------------------------------
// udp_checksum_pseudo_header
// UDP checksum engine over the datagram and the IPv4 pseudo-header.
// ----------------------------------------------------------------------------
// Datagram words enter one per cycle while the queue has space, network
// order, on in_i; the item with last_word set closes the datagram and
// carries src_ip/dst_ip. The front end accumulates the one's-complement sum
// and byte count word by word. Each finished datagram is queued (QueueDepth
// records) and the back end adds the pseudo-header, folds and inverts it in
// two register stages; the result passes the queue, stage A and the output
// register in turn before it is valid on out_o. A stalled output only stops
// the input once the queue is full.
// ----------------------------------------------------------------------------
module udp_checksum_pseudo_header #(
  parameter int unsigned QueueDepth = udpcs_pkg::QueueDepthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  udpcs_in_if.sink     in_i,
  udpcs_out_if.source  out_o
);

  logic            push, space, pop, q_valid;
  udpcs_pkg::rec_t rec_in, rec_out;

  udpcs_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push),
    .rec_o   (rec_in)
  );

  udpcs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (rec_out)
  );

  udpcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .rec_i   (rec_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_chk_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.checksum != 16'd0))
    else $error("checksum of zero presented");

  a_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.too_long) |-> (out_o.udp_length == udpcs_pkg::LenMax))
    else $error("oversized datagram without saturated length");

endmodule
